// ===== rtl/core/crc8_frame_checker_core_defines.svh =====
// Assertion macros for the frame checker RTL.
// Included by the deframer, which carries the concurrent checks; no other dependencies.
`ifndef CRC8_FRAME_CHECKER_CORE_DEFINES_SVH
`define CRC8_FRAME_CHECKER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define CRC8FC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("crc8fc assertion failed");
`define CRC8FC_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("crc8fc forbidden condition seen");
`else
`define CRC8FC_ASSERT(lbl, clk, rst_n, prop)
`define CRC8FC_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== rtl/core/crc8fc_pkg.sv =====
// Package for the CRC-8 frame checker: types, register codes, reset values
// and the byte-wise CRC-8 update. No dependencies.
package crc8fc_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] CRC_POLY       = 8'h07;
  localparam logic [BYTE_W-1:0] SYNC_RESET     = 8'd175;
  localparam logic [BYTE_W-1:0] MAX_LEN_RESET  = 8'hFF;
  localparam logic [BYTE_W-1:0] EXP_TYPE_RESET = 8'd7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_BYTE     = 2'd0,
    CFG_MAX_LENGTH    = 2'd1,
    CFG_EXPECTED_TYPE = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_e;

  typedef struct packed {
    logic [BYTE_W-1:0] sync_byte;
    logic [BYTE_W-1:0] max_length;
    logic [BYTE_W-1:0] expected_type;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] body_byte;
    logic [BYTE_W-1:0] body_index;
    logic              is_last;
    logic              crc_ok;
    logic              type_match;
    logic              length_error;
  } result_t;

  // deframer -> output register
  typedef struct packed {
    logic    push;
    result_t data;
  } push_t;

  // CRC-8, poly 0x07, MSB first
  function automatic logic [BYTE_W-1:0] crc8_update(logic [BYTE_W-1:0] crc,
                                                   logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] r;
    r = crc ^ data;
    for (int b = 0; b < BYTE_W; b++) begin
      if (r[BYTE_W-1]) begin
        r = {r[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[BYTE_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/crc8fc_if.sv =====
// Valid/ready channel interfaces of the frame checker: byte input, result
// output and register write. Depends on crc8fc_pkg.
interface crc8fc_rx_if;
  logic                             valid;
  logic                             ready;
  logic [crc8fc_pkg::BYTE_W-1:0]    rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crc8fc_res_if;
  logic                             valid;
  logic                             ready;
  logic [crc8fc_pkg::BYTE_W-1:0]    body_byte;
  logic [crc8fc_pkg::BYTE_W-1:0]    body_index;
  logic                             is_last;
  logic                             crc_ok;
  logic                             type_match;
  logic                             length_error;
  modport source (output valid, output body_byte, output body_index, output is_last,
                  output crc_ok, output type_match, output length_error, input ready);
  modport sink   (input valid, input body_byte, input body_index, input is_last,
                  input crc_ok, input type_match, input length_error, output ready);
endinterface

interface crc8fc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [crc8fc_pkg::CFG_IDX_W-1:0] index;
  logic [crc8fc_pkg::BYTE_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/crc8_frame_checker_core.sv =====
// Top level of the CRC-8 frame checker (sync, length, body, crc deframer).
// Depends on crc8fc_pkg, the channel interfaces and the three submodules.
//
// Usage
//  - rx_i : one received byte per request. Bytes other than the sync byte are
//           dropped while hunting; sync and good length bytes give no result.
//  - res_o: one request per body byte, with its index. The crc byte (is_last)
//           also carries crc_ok and type_match. A length of zero or above
//           max_length gives a single length_error request, then hunting.
//  - cfg_i: register writes (0 sync byte, 1 max length, 2 expected type),
//           always ready, take effect the next cycle. Write only when idle.
// Timing
//  - A byte is registered in the input register on acceptance and processed
//    from there; its result is registered in the result register for res_o.
//  - Throughput is one byte per cycle while res_o does not stall, set by the
//    combinational CRC update behind the input register.
//  - When res_o stalls, the result register holds its request; the input
//    register still takes one more byte and ready then drops until the
//    output frees (bytes that give no result keep flowing).
// Reset: asynchronous, active low; hunting, registers at their reset values.
module crc8_frame_checker_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  crc8fc_rx_if.sink     rx_i,
  crc8fc_res_if.source  res_o,
  crc8fc_cfg_if.sink    cfg_i
);

  crc8fc_pkg::cfg_t  cfg;
  crc8fc_pkg::push_t push;
  logic              out_free;

  // configuration registers
  crc8fc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // input register, frame state machine and crc
  crc8fc_deframer u_deframer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_i       (rx_i),
    .cfg_i      (cfg),
    .out_free_i (out_free),
    .push_o     (push)
  );

  // result register towards the sink
  crc8fc_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .out_free_o (out_free),
    .res_o      (res_o)
  );

endmodule

// ===== rtl/core/crc8fc_cfg_regs.sv =====
// Configuration register bank: sync byte, max length, expected type.
// Depends on crc8fc_pkg and crc8fc_cfg_if.
module crc8fc_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  crc8fc_cfg_if.sink          cfg_i,
  output crc8fc_pkg::cfg_t    cfg_o
);

  crc8fc_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (crc8fc_pkg::cfg_idx_e'(cfg_i.index))
        crc8fc_pkg::CFG_SYNC_BYTE:     cfg_d.sync_byte     = cfg_i.data;
        crc8fc_pkg::CFG_MAX_LENGTH:    cfg_d.max_length    = cfg_i.data;
        crc8fc_pkg::CFG_EXPECTED_TYPE: cfg_d.expected_type = cfg_i.data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_byte     <= crc8fc_pkg::SYNC_RESET;
      cfg_q.max_length    <= crc8fc_pkg::MAX_LEN_RESET;
      cfg_q.expected_type <= crc8fc_pkg::EXP_TYPE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/crc8fc_deframer.sv =====
// Input byte register plus the deframing state machine and CRC accumulator.
// Depends on crc8fc_pkg, crc8fc_rx_if and the assertion macro header.
`include "crc8_frame_checker_core_defines.svh"

module crc8fc_deframer (
  input  logic                clk_i,
  input  logic                rst_ni,
  crc8fc_rx_if.sink           rx_i,
  input  crc8fc_pkg::cfg_t    cfg_i,
  input  logic                out_free_i,
  output crc8fc_pkg::push_t   push_o
);

  localparam int unsigned W = crc8fc_pkg::BYTE_W;

  logic              rx_valid_q;
  logic [W-1:0]      rx_q;
  crc8fc_pkg::phase_e phase_q, phase_d;
  logic [W-1:0]      bytes_left_q, bytes_left_d;
  logic [W-1:0]      crc_q, crc_d;
  logic [W-1:0]      position_q, position_d;
  logic [W-1:0]      kind_q, kind_d;

  logic              has_result;
  logic              advance;
  logic              len_bad;
  logic [W-1:0]      kind_now;
  crc8fc_pkg::result_t res;

  assign len_bad  = (rx_q == '0) || (rx_q > cfg_i.max_length);
  assign kind_now = (position_q == '0) ? rx_q : kind_q;

  // byte leaves the input register once its result (if any) has a place
  assign advance     = rx_valid_q && (!has_result || out_free_i);
  assign rx_i.ready  = !rx_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_valid_q <= 1'b0;
    end else if (rx_i.valid && rx_i.ready) begin
      rx_valid_q <= 1'b1;
    end else if (advance) begin
      rx_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      rx_q <= rx_i.rx_byte;
    end
  end

  // next state
  always_comb begin
    phase_d      = phase_q;
    bytes_left_d = bytes_left_q;
    crc_d        = crc_q;
    position_d   = position_q;
    kind_d       = kind_q;
    if (advance) begin
      unique case (phase_q)
        crc8fc_pkg::PH_LEN: begin
          if (len_bad) begin
            phase_d = crc8fc_pkg::PH_HUNT;
          end else begin
            phase_d      = crc8fc_pkg::PH_BODY;
            bytes_left_d = rx_q;
            position_d   = '0;
            crc_d        = '0;
            kind_d       = '0;
          end
        end
        crc8fc_pkg::PH_BODY: begin
          kind_d = kind_now;
          if (bytes_left_q <= W'(1)) begin
            phase_d      = crc8fc_pkg::PH_HUNT;
            bytes_left_d = '0;
          end else begin
            crc_d        = crc8fc_pkg::crc8_update(crc_q, rx_q);
            bytes_left_d = bytes_left_q - W'(1);
            position_d   = position_q + W'(1);
          end
        end
        default: begin
          // hunting; the spare phase code hunts as well
          phase_d = (rx_q == cfg_i.sync_byte) ? crc8fc_pkg::PH_LEN : crc8fc_pkg::PH_HUNT;
        end
      endcase
    end
  end

  // result
  always_comb begin
    has_result = 1'b0;
    res        = '0;
    unique case (phase_q)
      crc8fc_pkg::PH_LEN: begin
        has_result       = rx_valid_q && len_bad;
        res.body_byte    = rx_q;
        res.is_last      = 1'b1;
        res.length_error = 1'b1;
      end
      crc8fc_pkg::PH_BODY: begin
        has_result     = rx_valid_q;
        res.body_byte  = rx_q;
        res.body_index = position_q;
        if (bytes_left_q <= W'(1)) begin
          res.is_last    = 1'b1;
          res.crc_ok     = (rx_q == crc_q);
          res.type_match = (kind_now == cfg_i.expected_type);
        end
      end
      default: has_result = 1'b0;
    endcase
  end

  assign push_o.push = advance && has_result;
  assign push_o.data = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= crc8fc_pkg::PH_HUNT;
      bytes_left_q <= '0;
      crc_q        <= '0;
      position_q   <= '0;
      kind_q       <= '0;
    end else begin
      phase_q      <= phase_d;
      bytes_left_q <= bytes_left_d;
      crc_q        <= crc_d;
      position_q   <= position_d;
      kind_q       <= kind_d;
    end
  end

  `CRC8FC_ASSERT(a_push_has_room, clk_i, rst_ni, push_o.push |-> out_free_i)
  `CRC8FC_ASSERT_NEVER(a_body_no_count, clk_i, rst_ni,
    (phase_q == crc8fc_pkg::PH_BODY) && (bytes_left_q == '0))
  `CRC8FC_ASSERT(a_last_to_hunt, clk_i, rst_ni,
    (push_o.push && push_o.data.is_last) |=> (phase_q == crc8fc_pkg::PH_HUNT))
  `CRC8FC_ASSERT(a_no_push_idle, clk_i, rst_ni, !rx_valid_q |-> !push_o.push)

endmodule

// ===== rtl/core/crc8fc_out_reg.sv =====
// Result register in front of the output channel; holds a result while the
// receiver stalls. Depends on crc8fc_pkg and crc8fc_res_if.
module crc8fc_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  crc8fc_pkg::push_t   push_i,
  output logic                out_free_o,
  crc8fc_res_if.source        res_o
);

  logic                valid_q;
  crc8fc_pkg::result_t data_q;

  assign out_free_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (out_free_o) begin
      valid_q <= push_i.push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free_o && push_i.push) begin
      data_q <= push_i.data;
    end
  end

  assign res_o.valid        = valid_q;
  assign res_o.body_byte    = data_q.body_byte;
  assign res_o.body_index   = data_q.body_index;
  assign res_o.is_last      = data_q.is_last;
  assign res_o.crc_ok       = data_q.crc_ok;
  assign res_o.type_match   = data_q.type_match;
  assign res_o.length_error = data_q.length_error;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for crc8_frame_checker_core: drives byte, result and register
// channels, predicts every result request and compares them field by field.
// Depends on crc8fc_pkg, the channel interfaces in crc8fc_if.sv and the core RTL.
module tb_top;

  localparam int unsigned CLK_PERIOD   = 12;
  localparam int unsigned RESET_CYCLES = 5;
  localparam int unsigned MAX_GAP      = 18;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS = 750;
  localparam int unsigned RAND_PHASES  = 5;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned BW           = crc8fc_pkg::BYTE_W;
  // index 3 decodes to no register and must be ignored
  localparam logic [crc8fc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  logic clk;
  logic rst_n;

  crc8fc_rx_if  rx_if ();
  crc8fc_res_if res_if ();
  crc8fc_cfg_if cfg_if ();

  crc8_frame_checker_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .rx_i   (rx_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // Deframer state and register shadow, updated on every accepted request
  crc8fc_pkg::cfg_t   reg_shadow;
  crc8fc_pkg::phase_e dfr_phase;
  logic [BW-1:0]      dfr_left;
  logic [BW-1:0]      dfr_crc;
  logic [BW-1:0]      dfr_pos;
  logic [BW-1:0]      dfr_kind;

  crc8fc_pkg::result_t due_results[$];

  int unsigned mismatch_count;
  int unsigned sent_bytes;
  int unsigned quiet_cycles;

  // Traffic shaping: burst mode for both sides, hold-offs and stalls for results
  bit          burst_mode;
  int unsigned hold_req;
  int unsigned res_wait;
  bit          res_taken;

  // Clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // All inputs known from time zero
  initial begin
    rst_n          = 1'b0;
    rx_if.valid    = 1'b0;
    rx_if.rx_byte  = '0;
    res_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = '0;
    cfg_if.data    = '0;
    burst_mode     = 1'b0;
    hold_req       = 0;
    res_wait       = 0;
    res_taken      = 1'b0;
    mismatch_count = 0;
    sent_bytes     = 0;
    quiet_cycles   = 0;
  end

  // CRC-8, poly 0x07, one data bit at a time, MSB first
  function automatic logic [BW-1:0] crc8_next(logic [BW-1:0] crc, logic [BW-1:0] data);
    logic [BW-1:0] acc;
    logic          fb;
    acc = crc;
    for (int i = BW - 1; i >= 0; i--) begin
      fb  = acc[BW-1] ^ data[i];
      acc = {acc[BW-2:0], 1'b0} ^ (fb ? crc8fc_pkg::CRC_POLY : '0);
    end
    return acc;
  endfunction

  // Deframer prediction for one accepted byte; queues the result it gives, if any
  task automatic deframe_byte(input logic [BW-1:0] b);
    crc8fc_pkg::result_t r;
    r = '0;
    case (dfr_phase)
      crc8fc_pkg::PH_LEN: begin
        if (b == '0 || b > reg_shadow.max_length) begin
          // bad length: single error request, back to hunting
          r.body_byte    = b;
          r.is_last      = 1'b1;
          r.length_error = 1'b1;
          due_results.push_back(r);
          dfr_phase = crc8fc_pkg::PH_HUNT;
        end else begin
          dfr_left  = b;
          dfr_pos   = '0;
          dfr_crc   = '0;
          dfr_kind  = '0;
          dfr_phase = crc8fc_pkg::PH_BODY;
        end
      end
      crc8fc_pkg::PH_BODY: begin
        if (dfr_pos == '0) dfr_kind = b;
        r.body_byte  = b;
        r.body_index = dfr_pos;
        if (dfr_left <= 8'd1) begin
          // crc byte: a one-byte body is checked against the empty-prefix crc
          r.is_last    = 1'b1;
          r.crc_ok     = (b == dfr_crc);
          r.type_match = (dfr_kind == reg_shadow.expected_type);
          dfr_phase    = crc8fc_pkg::PH_HUNT;
          dfr_left     = '0;
        end else begin
          dfr_crc  = crc8_next(dfr_crc, b);
          dfr_left = dfr_left - 8'd1;
          dfr_pos  = dfr_pos + 8'd1;
        end
        due_results.push_back(r);
      end
      default: begin
        // hunting: sync bytes inside a frame never reach here
        dfr_phase = (b == reg_shadow.sync_byte) ? crc8fc_pkg::PH_LEN : crc8fc_pkg::PH_HUNT;
      end
    endcase
  endtask

  // Send one byte request; entered and left at a falling edge
  task automatic send_byte(input logic [BW-1:0] b);
    int unsigned gap;
    gap = (burst_mode || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
    deframe_byte(b);
    sent_bytes++;
    @(negedge clk);
  endtask

  // Sync, length and body; the last body byte is the crc unless corrupted (kind for len 1)
  task automatic send_frame(input int unsigned len, input logic [BW-1:0] kind,
                            input bit bad_crc);
    logic [BW-1:0] crc;
    logic [BW-1:0] b;
    crc = '0;
    send_byte(reg_shadow.sync_byte);
    send_byte(len[BW-1:0]);
    for (int unsigned i = 0; i < len; i++) begin
      if (i == len - 1) begin
        b = (len == 1) ? kind : crc;
        if (bad_crc) b = b ^ 8'($urandom_range(1, 255));
      end else begin
        b   = (i == 0) ? kind : 8'($urandom_range(0, 255));
        crc = crc8_next(crc, b);
      end
      send_byte(b);
    end
  endtask

  task automatic send_bad_length(input logic [BW-1:0] len_byte);
    send_byte(reg_shadow.sync_byte);
    send_byte(len_byte);
  endtask

  // Every expected result in, then a drain wait for bytes that give none
  task automatic wait_idle();
    rx_if.valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Register write request; only called while idle
  task automatic write_reg(input logic [crc8fc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [BW-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      crc8fc_pkg::CFG_SYNC_BYTE:     reg_shadow.sync_byte     = d;
      crc8fc_pkg::CFG_MAX_LENGTH:    reg_shadow.max_length    = d;
      crc8fc_pkg::CFG_EXPECTED_TYPE: reg_shadow.expected_type = d;
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_regs(input logic [BW-1:0] sync_v, input logic [BW-1:0] max_v,
                          input logic [BW-1:0] type_v);
    write_reg(crc8fc_pkg::CFG_SYNC_BYTE, sync_v);
    write_reg(crc8fc_pkg::CFG_MAX_LENGTH, max_v);
    write_reg(crc8fc_pkg::CFG_EXPECTED_TYPE, type_v);
  endtask

  // Result side: per-request stall drawn after each acceptance, plus long hold-offs
  always @(negedge clk) begin
    if (res_taken) begin
      res_wait  = (burst_mode || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_GAP);
      res_taken = 1'b0;
    end
    if (hold_req > 0) begin
      res_wait = hold_req;
      hold_req = 0;
    end
    if (res_wait > 0) begin
      res_if.ready <= 1'b0;
      res_wait--;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Result checker: compare each accepted request with the oldest prediction
  always @(posedge clk) begin
    crc8fc_pkg::result_t exp_r;
    bit                  same;
    if (rst_n && res_if.valid && res_if.ready) begin
      res_taken = 1'b1;
      if (due_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected result byte=%0h idx=%0d last=%0b", $time,
                   res_if.body_byte, res_if.body_index, res_if.is_last);
      end else begin
        exp_r = due_results.pop_front();
        same  = (res_if.body_byte === exp_r.body_byte) &&
                (res_if.body_index === exp_r.body_index) &&
                (res_if.is_last === exp_r.is_last) &&
                (res_if.crc_ok === exp_r.crc_ok) &&
                (res_if.type_match === exp_r.type_match) &&
                (res_if.length_error === exp_r.length_error);
        if (!same) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display({"%0t: mismatch exp byte=%0h idx=%0d last=%0b ok=%0b tm=%0b le=%0b",
                      " got byte=%0h idx=%0d last=%0b ok=%0b tm=%0b le=%0b"}, $time,
                     exp_r.body_byte, exp_r.body_index, exp_r.is_last, exp_r.crc_ok,
                     exp_r.type_match, exp_r.length_error, res_if.body_byte,
                     res_if.body_index, res_if.is_last, res_if.crc_ok,
                     res_if.type_match, res_if.length_error);
        end
      end
    end
  end

  // Watchdog: cycles with no request accepted on any channel
  always @(posedge clk) begin
    if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Reset values: default sync 175, type 7, plus garbage and extremes
  task automatic test_reset_config();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(3, crc8fc_pkg::EXP_TYPE_RESET, 1'b0);
    send_frame(1, 8'h00, 1'b0);           // one-byte body, crc over nothing
    send_bad_length(8'h00);               // zero length
    send_frame(2, 8'hFF, 1'b1);
  endtask

  // Register extremes, sync value inside a body, ignored index
  task automatic test_register_extremes();
    wait_idle();
    set_regs(8'h00, 8'd1, 8'hFF);
    send_frame(1, 8'hFF, 1'b0);           // type matches, crc does not
    send_bad_length(8'd2);                // above max length
    wait_idle();
    write_reg(crc8fc_pkg::CFG_MAX_LENGTH, 8'h00);  // every length rejected
    send_bad_length(8'd1);
    wait_idle();
    set_regs(8'hFF, 8'hFF, 8'h00);
    write_reg(CFG_UNUSED_IDX, 8'($urandom_range(0, 255)));
    send_byte(8'hFF);                     // sync bytes as data within the frame
    send_byte(8'd3);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(crc8_next(crc8_next(8'h00, 8'h00), 8'hFF));
  endtask

  // Hold the result side off while a long frame keeps coming
  task automatic test_output_hold();
    wait_idle();
    set_regs(crc8fc_pkg::SYNC_RESET, crc8fc_pkg::MAX_LEN_RESET, crc8fc_pkg::EXP_TYPE_RESET);
    burst_mode = 1'b1;
    hold_req   = HOLD_CYCLES;
    send_frame(255, crc8fc_pkg::EXP_TYPE_RESET, 1'b0);
    burst_mode = 1'b0;
  endtask

  // Mostly well-formed frames with random content, some noise and broken ones
  task automatic test_random_traffic();
    int unsigned   sel;
    int unsigned   len;
    int unsigned   lim;
    logic [BW-1:0] kind;
    for (int unsigned p = 0; p < RAND_PHASES; p++) begin
      wait_idle();
      case (p)
        0: set_regs(crc8fc_pkg::SYNC_RESET, crc8fc_pkg::MAX_LEN_RESET,
                    crc8fc_pkg::EXP_TYPE_RESET);
        1: set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(2, 30)),
                    8'($urandom_range(0, 255)));
        2: set_regs(8'($urandom_range(0, 255)), 8'd1, 8'h00);
        default: set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)),
                          8'($urandom_range(0, 255)));
      endcase
      burst_mode = (p == 3);
      while (sent_bytes < RANDOM_ITEMS * (p + 1) / RAND_PHASES) begin
        sel  = $urandom_range(0, 99);
        kind = $urandom_range(0, 1) ? reg_shadow.expected_type : 8'($urandom_range(0, 255));
        lim  = (reg_shadow.max_length < 12) ? reg_shadow.max_length : 12;
        if (reg_shadow.max_length <= 40 && $urandom_range(0, 19) == 0)
          len = reg_shadow.max_length;
        else
          len = $urandom_range(1, lim);
        if (sel < 60) begin
          send_frame(len, kind, 1'b0);
        end else if (sel < 70) begin
          send_frame(len, kind, 1'b1);
        end else if (sel < 78) begin
          if (reg_shadow.max_length < 8'hFF && $urandom_range(0, 1))
            send_bad_length(8'($urandom_range(reg_shadow.max_length + 1, 255)));
          else
            send_bad_length(8'h00);
        end else if (sel < 86) begin
          // broken sequence: sync, any length, a few bytes, then carry on
          send_byte(reg_shadow.sync_byte);
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end else begin
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        end
      end
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    reg_shadow.sync_byte     = crc8fc_pkg::SYNC_RESET;
    reg_shadow.max_length    = crc8fc_pkg::MAX_LEN_RESET;
    reg_shadow.expected_type = crc8fc_pkg::EXP_TYPE_RESET;
    dfr_phase = crc8fc_pkg::PH_HUNT;
    dfr_left  = '0;
    dfr_crc   = '0;
    dfr_pos   = '0;
    dfr_kind  = '0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_config();
    test_register_extremes();
    test_output_hold();
    test_random_traffic();

    wait_idle();
    if (due_results.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
